/* design/segment_min_fingerprint_sampler_macros.svh */
// Assertion macros for the segment minimum fingerprint sampler.
`ifndef SEGMENT_MIN_FINGERPRINT_SAMPLER_MACROS_SVH
`define SEGMENT_MIN_FINGERPRINT_SAMPLER_MACROS_SVH

// Check that cond implies prop in the same cycle, outside reset.
`define SMFS_ASSERT_SAME(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("same-cycle check failed");

// Check that cond implies prop in the next cycle, outside reset.
`define SMFS_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("next-cycle check failed");

`endif

/* design/smfs_pkg.sv */
// Types and constants shared by the segment minimum fingerprint sampler.
package smfs_pkg;

  localparam int unsigned UPPER_BITS    = 64;
  localparam int unsigned MIDDLE_BITS   = 64;
  localparam int unsigned LOWER_BITS    = 32;
  localparam int unsigned FP_BITS       = UPPER_BITS + MIDDLE_BITS + LOWER_BITS;
  localparam int unsigned KIND_BITS     = 2;
  localparam int unsigned LIMIT_BITS    = 16;
  localparam int unsigned SEG_CNT_BITS  = 16;
  localparam int unsigned IN_DATA_BITS  = FP_BITS;
  localparam int unsigned OUT_DATA_BITS = FP_BITS + SEG_CNT_BITS;

  localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd128;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_CHUNK      = 2'd0,
    KIND_STREAM_END = 2'd1,
    KIND_FILE_END   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [UPPER_BITS-1:0]  upper;
    logic [MIDDLE_BITS-1:0] middle;
    logic [LOWER_BITS-1:0]  lower;
  } fp_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    fp_t                  fp;
  } item_t;

  typedef struct packed {
    fp_t                    rep;
    logic [SEG_CNT_BITS-1:0] segment_chunks;
  } result_t;

endpackage

/* design/segment_min_fingerprint_sampler.sv */
// Top level of the segment minimum fingerprint sampler.
// A closing word passes the input register and then the result register before out_tvalid.
// Throughput: one input word per cycle; input register, compare and result register.
// A stalled result register holds the input register; the input side keeps moving otherwise.
// Reset (rst_n low, synchronous): minimum all ones, chunk count zero, limit 128,
// both stages empty.
module segment_min_fingerprint_sampler #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // fp_upper [63:0], fp_middle [127:64], fp_lower [159:128]
  input  logic [smfs_pkg::IN_DATA_BITS-1:0]  in_tdata,
  // item_kind [1:0]
  input  logic [smfs_pkg::KIND_BITS-1:0]     in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // rep_upper [63:0], rep_middle [127:64], rep_lower [159:128], segment_chunks [175:160]
  output logic [smfs_pkg::OUT_DATA_BITS-1:0] out_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [smfs_pkg::LIMIT_BITS-1:0]    cfg_data
);
  import smfs_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.kind      = in_tuser;
  assign in_item.fp.upper  = in_tdata[63:0];
  assign in_item.fp.middle = in_tdata[127:64];
  assign in_item.fp.lower  = in_tdata[159:128];

  assign advance   = item_valid && (!out_tvalid || out_tready);
  assign cfg_ready = 1'b1;

  smfs_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  smfs_core #(
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .fire      (advance),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  smfs_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance && res_valid),
    .res       (res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {out_res.segment_chunks, out_res.rep.lower,
                      out_res.rep.middle, out_res.rep.upper};

`include "segment_min_fingerprint_sampler_macros.svh"

  `SMFS_ASSERT_SAME(a_ready_when_out_empty, !out_tvalid, in_tready)
  `SMFS_ASSERT_NEXT(a_stream_end_emits, advance && (item.kind == KIND_STREAM_END), out_tvalid)
  `SMFS_ASSERT_SAME(a_other_kinds_silent,
                    (item.kind != KIND_CHUNK) && (item.kind != KIND_STREAM_END), !res_valid)

endmodule

/* design/smfs_in_reg.sv */
// Input register stage of the segment minimum fingerprint sampler.
module smfs_in_reg (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  smfs_pkg::item_t in_item,
  input  logic            advance,
  output logic            item_valid,
  output smfs_pkg::item_t item
);
  import smfs_pkg::*;

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;

  assign in_ready  = !valid_r || advance;
  assign valid_nxt = in_ready ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

/* design/smfs_core.sv */
// Running minimum, chunk counter and segment boundary logic.
module smfs_core #(
  parameter int unsigned COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  input  logic [smfs_pkg::LIMIT_BITS-1:0] cfg_data,
  input  logic                            fire,
  input  smfs_pkg::item_t                 item,
  output logic                            res_valid,
  output smfs_pkg::result_t               res
);
  import smfs_pkg::*;

  localparam logic [COUNT_BITS-1:0] CountMax = {COUNT_BITS{1'b1}};

  logic [LIMIT_BITS-1:0] limit_r;
  fp_t                   min_r;
  fp_t                   min_nxt;
  logic [COUNT_BITS-1:0] cnt_r;
  logic [COUNT_BITS-1:0] cnt_nxt;
  logic [31:0]           cnt_wide;
  logic                  full;
  fp_t                   base_min;
  logic [COUNT_BITS-1:0] base_cnt;

  assign cnt_wide = 32'(cnt_r);
  assign full     = cnt_wide >= {16'd0, limit_r};
  assign base_min = full ? '1 : min_r;
  assign base_cnt = full ? '0 : cnt_r;

  always_comb begin
    min_nxt   = min_r;
    cnt_nxt   = cnt_r;
    res_valid = 1'b0;
    res.rep            = min_r;
    res.segment_chunks = cnt_wide[SEG_CNT_BITS-1:0];
    unique case (item.kind)
      KIND_STREAM_END: begin
        res_valid = 1'b1;
        min_nxt   = '1;
        cnt_nxt   = '0;
      end
      KIND_CHUNK: begin
        res_valid = full;
        cnt_nxt   = (base_cnt == CountMax) ? base_cnt : COUNT_BITS'(base_cnt + 1'b1);
        min_nxt   = (item.fp < base_min) ? item.fp : base_min;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= LIMIT_RESET;
      min_r   <= '1;
      cnt_r   <= '0;
    end else begin
      if (cfg_valid) begin
        limit_r <= cfg_data;
      end
      if (fire) begin
        min_r <= min_nxt;
        cnt_r <= cnt_nxt;
      end
    end
  end

endmodule

/* design/smfs_out_reg.sv */
// Result register stage of the segment minimum fingerprint sampler.
module smfs_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  smfs_pkg::result_t res,
  output logic              out_valid,
  input  logic              out_ready,
  output smfs_pkg::result_t out_res
);
  import smfs_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the segment minimum fingerprint sampler.
`timescale 1ns / 100ps

module tb_top;
  import smfs_pkg::*;

  localparam int unsigned COUNT_BITS = 16;
  localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;

  logic clk;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_BITS-1:0] in_tdata = '0;
  logic [KIND_BITS-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LIMIT_BITS-1:0] cfg_data = '0;

  segment_min_fingerprint_sampler #(.COUNT_BITS(COUNT_BITS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  item_t outgoing_items[$];
  result_t expected_segments[$];
  item_t drv_word;
  logic in_fire = 1'b0;
  int words_queued = 0;
  int words_sent = 0;
  int segments_checked = 0;
  int limit_settings = 1;
  int errors = 0;

  fp_t run_min = '1;
  logic [COUNT_BITS-1:0] chunk_count = '0;
  logic [LIMIT_BITS-1:0] seg_limit = LIMIT_RESET;

  int burst_left = 8;
  int gap_left = 0;
  int ready_run = 16;
  int ready_stall = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void fold_fingerprint(input item_t w);
    result_t seg;
    if (w.kind == KIND_STREAM_END || (w.kind == KIND_CHUNK && chunk_count >= seg_limit)) begin
      seg.rep = run_min;
      seg.segment_chunks = chunk_count[SEG_CNT_BITS-1:0];
      expected_segments.push_back(seg);
      run_min = '1;
      chunk_count = '0;
    end
    if (w.kind == KIND_CHUNK) begin
      if (chunk_count != '1) chunk_count = chunk_count + 1'b1;
      if (w.fp < run_min) run_min = w.fp;
    end
  endfunction

  function automatic logic [63:0] rand_part();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 64'($urandom_range(0, 3));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic fp_t rand_fp();
    fp_t f;
    logic [63:0] t;
    f.upper = rand_part();
    f.middle = rand_part();
    t = rand_part();
    f.lower = t[LOWER_BITS-1:0];
    return f;
  endfunction

  task automatic push_item(input logic [KIND_BITS-1:0] kind, input fp_t f);
    item_t it;
    it.kind = kind;
    it.fp = f;
    outgoing_items.push_back(it);
    words_queued++;
  endtask

  task automatic queue_random_items(input int n, input int end_pct);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < end_pct) push_item(KIND_STREAM_END, rand_fp());
      else if (r < end_pct + 8) push_item(KIND_FILE_END, rand_fp());
      else if (r < end_pct + 12) push_item(KIND_UNUSED, rand_fp());
      else push_item(KIND_CHUNK, rand_fp());
    end
  endtask

  task automatic wait_idle();
    while (words_sent != words_queued || expected_segments.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_limit(input logic [LIMIT_BITS-1:0] v);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    seg_limit = v;
    limit_settings++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // drive input words in bursts
  always @(negedge clk) begin
    logic next_valid;
    next_valid = in_tvalid && !in_fire;
    if (rst_n && !next_valid) begin
      if (gap_left > 0) begin
        gap_left--;
      end else if (outgoing_items.size() > 0) begin
        drv_word = outgoing_items.pop_front();
        in_tdata <= {drv_word.fp.lower, drv_word.fp.middle, drv_word.fp.upper};
        in_tuser <= drv_word.kind;
        next_valid = 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 32);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
    in_tvalid <= next_valid;
  end

  // stall the result side on runs of its own
  always @(negedge clk) begin
    logic next_ready;
    next_ready = 1'b1;
    if (ready_run > 0) begin
      ready_run--;
    end else if (ready_stall > 0) begin
      ready_stall--;
      next_ready = 1'b0;
    end else begin
      ready_run = $urandom_range(1, 24);
      ready_stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
    end
    out_tready <= next_ready;
  end

  always @(posedge clk) begin
    result_t want;
    in_fire <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      fold_fingerprint(drv_word);
      words_sent++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_segments.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, out_tdata);
        errors++;
      end else begin
        want = expected_segments.pop_front();
        check_field("rep_upper", want.rep.upper, out_tdata[63:0]);
        check_field("rep_middle", want.rep.middle, out_tdata[127:64]);
        check_field("rep_lower", 64'(want.rep.lower), 64'(out_tdata[159:128]));
        check_field("segment_chunks", 64'(want.segment_chunks), 64'(out_tdata[175:160]));
        segments_checked++;
      end
    end
  end

  initial begin
    fp_t f;
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;

    push_item(KIND_STREAM_END, rand_fp());
    push_item(KIND_CHUNK, '1);
    push_item(KIND_FILE_END, '0);
    push_item(KIND_UNUSED, '0);
    f.upper = 64'd5;
    f.middle = '1;
    f.lower = '1;
    push_item(KIND_CHUNK, f);
    f.middle = 64'd3;
    push_item(KIND_CHUNK, f);
    f.lower = 32'd9;
    push_item(KIND_CHUNK, f);
    push_item(KIND_CHUNK, f);
    f.upper = 64'd6;
    f.middle = '0;
    f.lower = '0;
    push_item(KIND_CHUNK, f);
    push_item(KIND_STREAM_END, rand_fp());
    push_item(KIND_CHUNK, '0);
    push_item(KIND_STREAM_END, '1);
    push_item(KIND_STREAM_END, '0);

    write_limit('0);
    push_item(KIND_CHUNK, rand_fp());
    push_item(KIND_CHUNK, rand_fp());
    push_item(KIND_STREAM_END, rand_fp());
    push_item(KIND_FILE_END, rand_fp());
    push_item(KIND_STREAM_END, rand_fp());

    write_limit(16'd2);
    repeat (5) push_item(KIND_CHUNK, rand_fp());
    push_item(KIND_STREAM_END, rand_fp());

    write_limit(LIMIT_RESET);
    queue_random_items(175, $urandom_range(1, 6));
    write_limit('0);
    queue_random_items(175, $urandom_range(1, 15));
    write_limit(16'd1);
    queue_random_items(175, $urandom_range(1, 15));
    write_limit(16'd3);
    queue_random_items(175, $urandom_range(1, 15));
    write_limit(16'($urandom_range(4, 40)));
    queue_random_items(175, $urandom_range(1, 10));
    write_limit(16'd7);
    queue_random_items(175, $urandom_range(1, 15));
    write_limit(16'd64);
    queue_random_items(175, $urandom_range(1, 4));
    write_limit(16'd2);
    queue_random_items(175, $urandom_range(1, 15));

    write_limit('1);
    repeat (20) push_item(KIND_CHUNK, rand_fp());
    push_item(KIND_STREAM_END, rand_fp());

    wait_idle();
    $display("Checked %0d segment results from %0d input words", segments_checked, words_sent);
    $display("over %0d chunk-limit settings, limits 0 and 65535 included.", limit_settings);
    if (errors == 0) begin
      $display("[segment_min_fingerprint_sampler] OK");
    end else begin
      $display("[segment_min_fingerprint_sampler] ERROR");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, expected_segments.size());
    $display("[segment_min_fingerprint_sampler] ERROR");
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/smfs_pkg.sv
design/smfs_in_reg.sv
design/smfs_core.sv
design/smfs_out_reg.sv
design/segment_min_fingerprint_sampler.sv
dv/tb_top.sv
